// ===== hdl/fam_pkg.sv =====
// Shared types, constants and microcode ROM for the fraction-add mixed-number block.
`timescale 1ns / 1ps

package fam_pkg;

    localparam int PART_WIDTH_DEF = 16;
    localparam int WHOLE_WIDTH    = 33;
    localparam int WORD_WIDTH     = 32;
    localparam int PC_WIDTH       = 5;

    typedef logic [PC_WIDTH-1:0] pc_t;

    // Datapath operations, one per microcode step
    typedef enum logic [4:0] {
        OP_NOP,
        OP_GCD_INIT,
        OP_DIV_XY,
        OP_GCD_WB,
        OP_DIV_BG,
        OP_FD_WB,
        OP_DIV_DG,
        OP_FB_WB,
        OP_DIV_AB,
        OP_Q1_WB,
        OP_DIV_CD,
        OP_Q2_WB,
        OP_MUL_LCM,
        OP_MUL_R1,
        OP_MUL_R2,
        OP_ROOM,
        OP_FIN,
        OP_EMIT,
        OP_EMIT_ERR
    } dp_op_t;

    // Sequencing conditions
    typedef enum logic [2:0] {
        BR_NEXT,
        BR_JUMP,
        BR_BAD,
        BR_YZERO,
        BR_WAIT,
        BR_HALT
    } br_cond_t;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } seq_state_t;

    typedef struct packed {
        dp_op_t   op;
        br_cond_t cond;
        pc_t      target;
    } ucode_word_t;

    typedef struct packed {
        dp_op_t op;
        logic   go;
    } dp_ctrl_t;

    typedef struct packed {
        logic bad;
        logic y_zero;
        logic div_done;
        logic out_free;
    } dp_flags_t;

    // Program labels
    localparam pc_t PC_CHECK   = 5'd0;
    localparam pc_t PC_INIT    = 5'd1;
    localparam pc_t PC_LOOP    = 5'd2;
    localparam pc_t PC_DIV_XY  = 5'd3;
    localparam pc_t PC_GCD_WB  = 5'd4;
    localparam pc_t PC_DIV_BG  = 5'd5;
    localparam pc_t PC_FD_WB   = 5'd6;
    localparam pc_t PC_DIV_DG  = 5'd7;
    localparam pc_t PC_FB_WB   = 5'd8;
    localparam pc_t PC_DIV_AB  = 5'd9;
    localparam pc_t PC_Q1_WB   = 5'd10;
    localparam pc_t PC_DIV_CD  = 5'd11;
    localparam pc_t PC_Q2_WB   = 5'd12;
    localparam pc_t PC_MUL_LCM = 5'd13;
    localparam pc_t PC_MUL_R1  = 5'd14;
    localparam pc_t PC_MUL_R2  = 5'd15;
    localparam pc_t PC_ROOM    = 5'd16;
    localparam pc_t PC_FIN     = 5'd17;
    localparam pc_t PC_EMIT    = 5'd18;
    localparam pc_t PC_ERR     = 5'd19;

    function automatic ucode_word_t ucode_rom(pc_t pc);
        ucode_word_t w;
        case (pc)
            PC_CHECK:   w = '{OP_NOP,      BR_BAD,   PC_ERR};
            PC_INIT:    w = '{OP_GCD_INIT, BR_NEXT,  PC_CHECK};
            PC_LOOP:    w = '{OP_NOP,      BR_YZERO, PC_DIV_BG};
            PC_DIV_XY:  w = '{OP_DIV_XY,   BR_NEXT,  PC_CHECK};
            PC_GCD_WB:  w = '{OP_GCD_WB,   BR_WAIT,  PC_LOOP};
            PC_DIV_BG:  w = '{OP_DIV_BG,   BR_NEXT,  PC_CHECK};
            PC_FD_WB:   w = '{OP_FD_WB,    BR_WAIT,  PC_DIV_DG};
            PC_DIV_DG:  w = '{OP_DIV_DG,   BR_NEXT,  PC_CHECK};
            PC_FB_WB:   w = '{OP_FB_WB,    BR_WAIT,  PC_DIV_AB};
            PC_DIV_AB:  w = '{OP_DIV_AB,   BR_NEXT,  PC_CHECK};
            PC_Q1_WB:   w = '{OP_Q1_WB,    BR_WAIT,  PC_DIV_CD};
            PC_DIV_CD:  w = '{OP_DIV_CD,   BR_NEXT,  PC_CHECK};
            PC_Q2_WB:   w = '{OP_Q2_WB,    BR_WAIT,  PC_MUL_LCM};
            PC_MUL_LCM: w = '{OP_MUL_LCM,  BR_NEXT,  PC_CHECK};
            PC_MUL_R1:  w = '{OP_MUL_R1,   BR_NEXT,  PC_CHECK};
            PC_MUL_R2:  w = '{OP_MUL_R2,   BR_NEXT,  PC_CHECK};
            PC_ROOM:    w = '{OP_ROOM,     BR_NEXT,  PC_CHECK};
            PC_FIN:     w = '{OP_FIN,      BR_JUMP,  PC_EMIT};
            PC_EMIT:    w = '{OP_EMIT,     BR_HALT,  PC_CHECK};
            PC_ERR:     w = '{OP_EMIT_ERR, BR_HALT,  PC_CHECK};
            default:    w = '{OP_NOP,      BR_JUMP,  PC_ERR};
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/fam_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module fam_div #(
    parameter int W = fam_pkg::PART_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder,
    output logic         done
);

    localparam int CNT_W = $clog2(W);

    logic [W-1:0]     quo_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;

    logic [W:0] shifted;
    logic [W:0] trial;
    logic       fits;

    assign shifted = {rem_reg, quo_reg[W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};
    assign fits    = (shifted >= {1'b0, dvs_reg});

    always_ff @(posedge clk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (run_reg) begin
            quo_reg <= {quo_reg[W-2:0], fits};
            rem_reg <= fits ? trial[W-1:0] : shifted[W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (run_reg) begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(W - 1)) begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

// ===== hdl/fam_seq.sv =====
// Microcode sequencer: step counter, ROM fetch and branch logic.
`timescale 1ns / 1ps

module fam_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  fam_pkg::dp_flags_t  flags,
    output fam_pkg::dp_ctrl_t   ctrl,
    output logic                in_accept
);

    fam_pkg::seq_state_t  state_reg;
    fam_pkg::seq_state_t  state_next;
    fam_pkg::pc_t         pc_reg;
    fam_pkg::pc_t         pc_next;
    fam_pkg::ucode_word_t uw;
    logic                 go;

    assign uw = fam_pkg::ucode_rom(pc_reg);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= fam_pkg::SEQ_IDLE;
            pc_reg    <= fam_pkg::PC_CHECK;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        pc_next    = pc_reg;
        go         = 1'b0;
        in_ready   = 1'b0;
        case (state_reg)
            fam_pkg::SEQ_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    state_next = fam_pkg::SEQ_RUN;
                    pc_next    = fam_pkg::PC_CHECK;
                end
            end
            fam_pkg::SEQ_RUN: begin
                case (uw.cond)
                    fam_pkg::BR_NEXT: begin
                        go      = 1'b1;
                        pc_next = pc_reg + fam_pkg::pc_t'(1);
                    end
                    fam_pkg::BR_JUMP: begin
                        go      = 1'b1;
                        pc_next = uw.target;
                    end
                    fam_pkg::BR_BAD: begin
                        go      = 1'b1;
                        pc_next = flags.bad ? uw.target : pc_reg + fam_pkg::pc_t'(1);
                    end
                    fam_pkg::BR_YZERO: begin
                        go      = 1'b1;
                        pc_next = flags.y_zero ? uw.target : pc_reg + fam_pkg::pc_t'(1);
                    end
                    fam_pkg::BR_WAIT: begin
                        go = flags.div_done;
                        if (flags.div_done) begin
                            pc_next = uw.target;
                        end
                    end
                    fam_pkg::BR_HALT: begin
                        go = flags.out_free;
                        if (flags.out_free) begin
                            state_next = fam_pkg::SEQ_IDLE;
                            pc_next    = fam_pkg::PC_CHECK;
                        end
                    end
                    default: begin
                        go      = 1'b1;
                        pc_next = fam_pkg::PC_ERR;
                    end
                endcase
            end
            default: begin
                state_next = fam_pkg::SEQ_IDLE;
            end
        endcase
    end

    assign ctrl.op   = uw.op;
    assign ctrl.go   = go;
    assign in_accept = in_valid && in_ready;

endmodule

// ===== hdl/fam_dp.sv =====
// Datapath: operand registers, shared divider and multiplier, result register.
`timescale 1ns / 1ps

module fam_dp #(
    parameter int W = fam_pkg::PART_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_accept,
    input  logic [W-1:0]                        first_numerator,
    input  logic [W-1:0]                        first_denominator,
    input  logic [W-1:0]                        second_numerator,
    input  logic [W-1:0]                        second_denominator,
    input  fam_pkg::dp_ctrl_t                   ctrl,
    output fam_pkg::dp_flags_t                  flags,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [fam_pkg::WHOLE_WIDTH-1:0]     whole_part,
    output logic [fam_pkg::WORD_WIDTH-1:0]      remainder_numerator,
    output logic [fam_pkg::WORD_WIDTH-1:0]      result_denominator,
    output logic                                bad_input
);

    localparam int LW      = 2 * W;
    localparam int HW      = W + 1;
    localparam int WHOLE_W = fam_pkg::WHOLE_WIDTH;
    localparam int WORD_W  = fam_pkg::WORD_WIDTH;

    logic [W-1:0]  a_reg, b_reg, c_reg, d_reg;
    logic [W-1:0]  x_reg, y_reg;
    logic [W-1:0]  fb_reg, fd_reg;
    logic [W-1:0]  q1_reg, q2_reg, r1a_reg, r2a_reg;
    logic [LW-1:0] lcm_reg, p1_reg, p2_reg, room_reg, rem_reg;
    logic [HW-1:0] whole_reg;

    logic [WHOLE_W-1:0] whole_out_reg;
    logic [WORD_W-1:0]  rem_out_reg;
    logic [WORD_W-1:0]  den_out_reg;
    logic               bad_out_reg;
    logic               out_valid_reg;

    logic          div_start;
    logic [W-1:0]  div_dvd, div_dvs;
    logic [W-1:0]  div_quo, div_rem;
    logic          div_done;
    logic [W-1:0]  mul_a, mul_b;
    logic [LW-1:0] mul_p;
    logic          emit;

    fam_div #(.W(W)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .quotient  (div_quo),
        .remainder (div_rem),
        .done      (div_done)
    );

    // operand select for the divider and the multiplier
    always_comb begin
        div_start = ctrl.go && (ctrl.op inside {fam_pkg::OP_DIV_XY, fam_pkg::OP_DIV_BG,
                                                fam_pkg::OP_DIV_DG, fam_pkg::OP_DIV_AB,
                                                fam_pkg::OP_DIV_CD});
        case (ctrl.op)
            fam_pkg::OP_DIV_BG: begin div_dvd = b_reg; div_dvs = x_reg; end
            fam_pkg::OP_DIV_DG: begin div_dvd = d_reg; div_dvs = x_reg; end
            fam_pkg::OP_DIV_AB: begin div_dvd = a_reg; div_dvs = b_reg; end
            fam_pkg::OP_DIV_CD: begin div_dvd = c_reg; div_dvs = d_reg; end
            default:            begin div_dvd = x_reg; div_dvs = y_reg; end
        endcase
        case (ctrl.op)
            fam_pkg::OP_MUL_R1: begin mul_a = r1a_reg; mul_b = fb_reg; end
            fam_pkg::OP_MUL_R2: begin mul_a = r2a_reg; mul_b = fd_reg; end
            default:            begin mul_a = fd_reg;  mul_b = d_reg;  end
        endcase
    end

    assign mul_p = LW'(mul_a) * LW'(mul_b);
    assign emit  = ctrl.go && (ctrl.op inside {fam_pkg::OP_EMIT, fam_pkg::OP_EMIT_ERR});

    always_ff @(posedge clk) begin
        if (in_accept) begin
            a_reg <= first_numerator;
            b_reg <= first_denominator;
            c_reg <= second_numerator;
            d_reg <= second_denominator;
        end
        if (ctrl.go) begin
            case (ctrl.op)
                fam_pkg::OP_GCD_INIT: begin
                    x_reg <= b_reg;
                    y_reg <= d_reg;
                end
                fam_pkg::OP_GCD_WB: begin
                    x_reg <= y_reg;
                    y_reg <= div_rem;
                end
                fam_pkg::OP_FD_WB: fd_reg <= div_quo;
                fam_pkg::OP_FB_WB: fb_reg <= div_quo;
                fam_pkg::OP_Q1_WB: begin
                    q1_reg  <= div_quo;
                    r1a_reg <= div_rem;
                end
                fam_pkg::OP_Q2_WB: begin
                    q2_reg  <= div_quo;
                    r2a_reg <= div_rem;
                end
                fam_pkg::OP_MUL_LCM: lcm_reg <= mul_p;
                fam_pkg::OP_MUL_R1:  p1_reg  <= mul_p;
                fam_pkg::OP_MUL_R2:  p2_reg  <= mul_p;
                fam_pkg::OP_ROOM: begin
                    room_reg  <= lcm_reg - p2_reg;
                    whole_reg <= HW'(q1_reg) + HW'(q2_reg);
                end
                fam_pkg::OP_FIN: begin
                    // fractional parts carry into the whole part at most once
                    if (p1_reg >= room_reg) begin
                        rem_reg   <= p1_reg - room_reg;
                        whole_reg <= whole_reg + HW'(1);
                    end else begin
                        rem_reg <= p1_reg + p2_reg;
                    end
                end
                fam_pkg::OP_EMIT: begin
                    whole_out_reg <= WHOLE_W'(whole_reg);
                    rem_out_reg   <= WORD_W'(rem_reg);
                    den_out_reg   <= (rem_reg == '0) ? '0 : WORD_W'(lcm_reg);
                    bad_out_reg   <= 1'b0;
                end
                fam_pkg::OP_EMIT_ERR: begin
                    whole_out_reg <= '0;
                    rem_out_reg   <= '0;
                    den_out_reg   <= '0;
                    bad_out_reg   <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign flags.bad      = (b_reg == '0) || (d_reg == '0);
    assign flags.y_zero   = (y_reg == '0);
    assign flags.div_done = div_done;
    assign flags.out_free = !out_valid_reg || out_ready;

    assign out_valid           = out_valid_reg;
    assign whole_part          = whole_out_reg;
    assign remainder_numerator = rem_out_reg;
    assign result_denominator  = den_out_reg;
    assign bad_input           = bad_out_reg;

endmodule

// ===== hdl/fraction_add_mixed_number.sv =====
// Top level of the fraction-add mixed-number block.
`timescale 1ns / 1ps

// Adds two unsigned fractions a/b and c/d (PART_WIDTH-bit parts) and returns
// the sum as a mixed number: whole part, unreduced remainder over lcm(b,d),
// and that common denominator, which reads 0 when the remainder is zero.
// Sums are exact; outputs are truncated to their port widths. A zero
// denominator gives bad_input = 1 with all other result fields zero.
// One transaction at a time: in_ready is high only while the sequencer is
// idle. The work runs as a microcode program on a datapath with one shared
// radix-2 divider and one shared multiplier. Run time grows with k, the
// number of Euclid remainder steps for the GCD (k is at most about 1.44*W
// with W = PART_WIDTH, e.g. 23 for W = 16). A bad item goes from the check
// step straight to the error result. The output register frees the
// datapath: a finished result may wait while the next transaction is
// accepted, and the next result only stalls if the previous one is still
// untaken when it is ready.

module fraction_add_mixed_number #(
    parameter int PART_WIDTH = fam_pkg::PART_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [PART_WIDTH-1:0]            first_numerator,
    input  logic [PART_WIDTH-1:0]            first_denominator,
    input  logic [PART_WIDTH-1:0]            second_numerator,
    input  logic [PART_WIDTH-1:0]            second_denominator,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [fam_pkg::WHOLE_WIDTH-1:0]  whole_part,
    output logic [fam_pkg::WORD_WIDTH-1:0]   remainder_numerator,
    output logic [fam_pkg::WORD_WIDTH-1:0]   result_denominator,
    output logic                             bad_input
);

    fam_pkg::dp_ctrl_t  ctrl;
    fam_pkg::dp_flags_t flags;
    logic               in_accept;

    // sequencer: fetches one control word per step from the microcode ROM
    fam_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .flags     (flags),
        .ctrl      (ctrl),
        .in_accept (in_accept)
    );

    // datapath: operand latch, GCD/LCM, scaling, carry-in and result register
    fam_dp #(.W(PART_WIDTH)) u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_accept           (in_accept),
        .first_numerator     (first_numerator),
        .first_denominator   (first_denominator),
        .second_numerator    (second_numerator),
        .second_denominator  (second_denominator),
        .ctrl                (ctrl),
        .flags               (flags),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .whole_part          (whole_part),
        .remainder_numerator (remainder_numerator),
        .result_denominator  (result_denominator),
        .bad_input           (bad_input)
    );

`ifndef SYNTHESIS
    // in_ready is low in the cycle after a transaction is accepted
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !in_ready)
        else $error("in_ready high right after accepting a transaction");

    // error results carry zero fields
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bad_input) |-> (whole_part == '0 && remainder_numerator == '0
                                      && result_denominator == '0))
        else $error("bad_input result with nonzero fields");

    // exact sums report a zero remainder
    a_exact_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !bad_input && result_denominator == '0)
            |-> (remainder_numerator == '0))
        else $error("zero denominator reported with nonzero remainder");

    // the sequencer only advances a write-back step when the divider finishes
    a_wait_div: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.go && (ctrl.op == fam_pkg::OP_GCD_WB || ctrl.op == fam_pkg::OP_Q1_WB
                     || ctrl.op == fam_pkg::OP_Q2_WB)) |-> flags.div_done)
        else $error("divider result taken before done");
`endif

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the fraction-add mixed-number block.
`timescale 1ns / 1ps

module tb;

    localparam int PW          = fam_pkg::PART_WIDTH_DEF;
    localparam int RANDOM_ITEMS = 430;
    localparam int STALL_LIMIT = 5000;   // cycles with no handshake before giving up
    localparam int DRAIN_TAIL  = 600;    // longer than the slowest GCD + divide run
    localparam int IDLE_PCT    = 37;

    typedef struct {
        logic [PW-1:0] a_num;
        logic [PW-1:0] a_den;
        logic [PW-1:0] c_num;
        logic [PW-1:0] c_den;
    } fraction_pair_t;

    typedef struct {
        logic [fam_pkg::WHOLE_WIDTH-1:0] whole;
        logic [fam_pkg::WORD_WIDTH-1:0]  rem;
        logic [fam_pkg::WORD_WIDTH-1:0]  den;
        logic                            bad;
    } mixed_number_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic          in_valid = 1'b0;
    logic          in_ready;
    logic [PW-1:0] first_numerator = '0;
    logic [PW-1:0] first_denominator = '0;
    logic [PW-1:0] second_numerator = '0;
    logic [PW-1:0] second_denominator = '0;

    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [fam_pkg::WHOLE_WIDTH-1:0] whole_part;
    logic [fam_pkg::WORD_WIDTH-1:0]  remainder_numerator;
    logic [fam_pkg::WORD_WIDTH-1:0]  result_denominator;
    logic                            bad_input;

    fraction_pair_t fraction_queue[$];   // stimulus not yet presented
    mixed_number_t  pending_sums[$];     // predicted results, oldest first

    int mismatch_count = 0;
    int accepted_count = 0;
    int stall_cycles   = 0;
    logic calm;

    fraction_add_mixed_number #(
        .PART_WIDTH (PW)
    ) i_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .first_numerator     (first_numerator),
        .first_denominator   (first_denominator),
        .second_numerator    (second_numerator),
        .second_denominator  (second_denominator),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .whole_part          (whole_part),
        .remainder_numerator (remainder_numerator),
        .result_denominator  (result_denominator),
        .bad_input           (bad_input)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Window of transactions where neither side throttles, so the block runs
    // back to back and the output register gets exercised under load.
    assign calm = (accepted_count >= 150) && (accepted_count < 250);

    // Exact sum a/b + c/d as a mixed number over lcm(b, d). Fractional
    // parts are added apart from the integer parts so nothing overflows.
    function automatic mixed_number_t mixed_sum(fraction_pair_t f);
        mixed_number_t     m;
        longint unsigned   x, y, t, lcm, r1, r2, room, rem, whole;
        m = '{whole: '0, rem: '0, den: '0, bad: 1'b0};
        if (f.a_den == 0 || f.c_den == 0)
        begin
            m.bad = 1'b1;
            return m;
        end
        x = f.a_den;
        y = f.c_den;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        lcm   = (f.a_den / x) * f.c_den;
        whole = f.a_num / f.a_den + f.c_num / f.c_den;
        r1    = (f.a_num % f.a_den) * (lcm / f.a_den);
        r2    = (f.c_num % f.c_den) * (lcm / f.c_den);
        room  = lcm - r2;
        if (r1 >= room)
        begin
            rem   = r1 - room;
            whole = whole + 1;
        end
        else
        begin
            rem = r1 + r2;
        end
        m.whole = whole[fam_pkg::WHOLE_WIDTH-1:0];
        m.rem   = rem[fam_pkg::WORD_WIDTH-1:0];
        m.den   = (rem == 0) ? '0 : lcm[fam_pkg::WORD_WIDTH-1:0];
        return m;
    endfunction

    task automatic log_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t ns: %s", $time, msg);
    endtask

    task automatic push_item(input logic [PW-1:0] a, b, c, d);
        fraction_queue.push_back('{a_num: a, a_den: b, c_num: c, c_den: d});
    endtask

    function automatic logic [PW-1:0] odd_denominator();
        case ($urandom_range(0, 5))
            0:       return PW'(1);
            1:       return 16'hFFFF;
            2:       return 16'hFFFE;
            3:       return 16'h8000;
            4:       return 16'h0001 << $urandom_range(0, PW - 1);
            default: return PW'($urandom_range(1, 65535));
        endcase
    endfunction

    // Driver: presents the next queued fraction pair once the current one is
    // taken; valid holds with a steady payload until the handshake.
    always @(posedge clk)
    begin : driver
        fraction_pair_t next_item;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                pending_sums.push_back(mixed_sum('{a_num: first_numerator,
                                                   a_den: first_denominator,
                                                   c_num: second_numerator,
                                                   c_den: second_denominator}));
                accepted_count++;
            end
            if (!in_valid || in_ready)
            begin
                if (fraction_queue.size() == 0 ||
                    (!calm && $urandom_range(0, 99) < IDLE_PCT))
                begin
                    in_valid <= 1'b0;
                end
                else
                begin
                    next_item = fraction_queue.pop_front();
                    in_valid           <= 1'b1;
                    first_numerator    <= next_item.a_num;
                    first_denominator  <= next_item.a_den;
                    second_numerator   <= next_item.c_num;
                    second_denominator <= next_item.c_den;
                end
            end
        end
    end

    // Monitor: checks every result transaction against the oldest prediction
    // and throttles out_ready at random outside the calm window.
    always @(posedge clk)
    begin : monitor
        mixed_number_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_sums.size() == 0)
                begin
                    log_mismatch($sformatf("result with nothing expected: whole=%0d rem=%0d den=%0d bad=%0b",
                                           whole_part, remainder_numerator,
                                           result_denominator, bad_input));
                end
                else
                begin
                    want = pending_sums.pop_front();
                    if (whole_part !== want.whole)
                        log_mismatch($sformatf("whole_part: expected %0d, got %0d",
                                               want.whole, whole_part));
                    if (remainder_numerator !== want.rem)
                        log_mismatch($sformatf("remainder_numerator: expected %0d, got %0d",
                                               want.rem, remainder_numerator));
                    if (result_denominator !== want.den)
                        log_mismatch($sformatf("result_denominator: expected %0d, got %0d",
                                               want.den, result_denominator));
                    if (bad_input !== want.bad)
                        log_mismatch($sformatf("bad_input: expected %0b, got %0b",
                                               want.bad, bad_input));
                end
            end
            out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Watchdog on handshake progress.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        int               kind;
        int               g;
        logic [PW-1:0]    a, b, c, d;

        // Directed: extremes, both-ones lcm, exact sums, zero denominators,
        // alternating bit patterns and a worst case for Euclid (Fibonacci).
        push_item(0, 1, 0, 1);
        push_item(1, 1, 1, 1);
        push_item(16'hFFFF, 1, 16'hFFFF, 1);
        push_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_item(16'hFFFE, 16'hFFFF, 16'hFFFD, 16'hFFFE);   // largest lcm
        push_item(1, 16'hFFFF, 1, 16'hFFFE);
        push_item(1, 2, 1, 2);
        push_item(3, 4, 3, 4);
        push_item(1, 3, 1, 6);
        push_item(5, 0, 7, 3);
        push_item(5, 3, 7, 0);
        push_item(16'hFFFF, 0, 16'hFFFF, 0);
        push_item(0, 0, 0, 0);
        push_item(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA);
        push_item(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555);
        push_item(0, 16'h8000, 16'h7FFF, 16'h8000);
        push_item(16'hFFFF, 2, 16'hFFFF, 3);
        push_item(12345, 4096, 54321, 6144);
        push_item(7, 46368, 11, 28657);
        push_item(16'hFFFF, 46368, 16'hFFFF, 28657);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 45)
            begin
                // full range; zero denominators turn up now and then
                a = PW'($urandom);
                b = PW'($urandom);
                c = PW'($urandom);
                d = PW'($urandom);
            end
            else if (kind < 65)
            begin
                // tiny denominators: frequent exact sums and carries
                a = PW'($urandom_range(0, 200));
                b = PW'($urandom_range(1, 12));
                c = PW'($urandom_range(0, 200));
                d = PW'($urandom_range(1, 12));
            end
            else if (kind < 75)
            begin
                // shared factor so the GCD is not trivial
                g = $urandom_range(1, 255);
                a = PW'($urandom);
                b = PW'(g * $urandom_range(1, 255));
                c = PW'($urandom);
                d = PW'(g * $urandom_range(1, 255));
            end
            else if (kind < 85)
            begin
                a = PW'($urandom);
                c = PW'($urandom);
                b = $urandom_range(0, 1) ? 16'd0 : PW'($urandom);
                d = (b != 0 || $urandom_range(0, 1)) ? 16'd0 : PW'($urandom);
            end
            else
            begin
                a = PW'($urandom) >> $urandom_range(0, PW - 1);
                b = odd_denominator();
                c = PW'($urandom) >> $urandom_range(0, PW - 1);
                d = odd_denominator();
            end
            push_item(a, b, c, d);
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // sampled mid-cycle so the driver's updates at the edge have settled
        while (fraction_queue.size() > 0 || in_valid)
            @(negedge clk);
        while (pending_sums.size() > 0)
            @(negedge clk);
        // stray results after the last expected one get caught here
        repeat (DRAIN_TAIL) @(posedge clk);

        if (mismatch_count == 0 && pending_sums.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/fam_pkg.sv
hdl/fam_div.sv
hdl/fam_seq.sv
hdl/fam_dp.sv
hdl/fraction_add_mixed_number.sv
test/tb.sv
